@@ src/icfm_pkg.sv @@
// ----------------------------------------------------------------------------
// icfm_pkg
// Shared widths, register codes and control types for the input capture
// frequency meter.
// ----------------------------------------------------------------------------
package icfm_pkg;

  localparam int CLOCK_W     = 28;
  localparam int PRESCALE_W  = 16;
  localparam int CAPTURE_W   = 32;
  localparam int FREQ_W      = 36;
  localparam int FRAC_W      = 8;
  localparam int DEN_W       = 48;
  localparam int DIV_STEPS   = FREQ_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = CLOCK_W;

  localparam logic [CLOCK_W-1:0]    TIMER_CLOCK_RESET = 28'd48000000;
  localparam logic [PRESCALE_W-1:0] PRESCALE_RESET    = 16'd1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TIMER_CLOCK = 1'b0,
    REG_PRESCALE    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic store_first;
    logic store_period;
    logic load_div;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

@@ src/icfm_datapath.sv @@
// ----------------------------------------------------------------------------
// icfm_datapath
// Configuration registers, capture storage, period subtractor, denominator
// multiplier, restoring divider and the output register.
// ----------------------------------------------------------------------------
module icfm_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [icfm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [icfm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [icfm_pkg::CAPTURE_W-1:0]      capture_value,
  input  icfm_pkg::dp_cmd_t                   cmd,
  output icfm_pkg::dp_status_t                status,
  output logic [icfm_pkg::CAPTURE_W-1:0]      period_ticks,
  output logic [icfm_pkg::FREQ_W-1:0]         frequency_q8,
  output logic                                zero_period_error
);
  import icfm_pkg::*;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST_COUNT = DIV_CNT_W'(DIV_STEPS - 1);

  logic [CLOCK_W-1:0]    timer_clock_hz;
  logic [PRESCALE_W-1:0] prescale_divisor_minus_one;
  logic [CAPTURE_W-1:0]  first_timestamp;
  logic [CAPTURE_W-1:0]  period;
  logic [DEN_W-1:0]      den;
  logic [FREQ_W-1:0]     rem;
  logic [FREQ_W-1:0]     quo;
  logic [DIV_CNT_W-1:0]  div_count;

  logic [PRESCALE_W:0]             prescale_plus_one;
  logic [PRESCALE_W+CAPTURE_W:0]   product;
  logic [FREQ_W:0]                 trial;
  logic                            trial_ge;

  assign prescale_plus_one = {1'b0, prescale_divisor_minus_one} + (PRESCALE_W+1)'(1);
  assign product = {{(CAPTURE_W){1'b0}}, prescale_plus_one}
                 * {{(PRESCALE_W+1){1'b0}}, period};
  assign trial    = {rem, quo[FREQ_W-1]};
  assign trial_ge = {{(DEN_W-FREQ_W-1){1'b0}}, trial} >= den;

  assign status.div_last = (div_count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_clock_hz             <= TIMER_CLOCK_RESET;
      prescale_divisor_minus_one <= PRESCALE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TIMER_CLOCK: timer_clock_hz <= cfg_data[CLOCK_W-1:0];
        REG_PRESCALE:    prescale_divisor_minus_one <= cfg_data[PRESCALE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_first) begin
      first_timestamp <= capture_value;
    end
    if (cmd.store_period) begin
      period <= capture_value - first_timestamp;
    end
    if (cmd.load_div) begin
      den       <= product[DEN_W-1:0];
      rem       <= '0;
      quo       <= {timer_clock_hz, {FRAC_W{1'b0}}};
      div_count <= DIV_LAST_COUNT;
    end else if (cmd.div_step) begin
      if (trial_ge) begin
        rem <= FREQ_W'(trial - den[FREQ_W:0]);
      end else begin
        rem <= trial[FREQ_W-1:0];
      end
      quo       <= {quo[FREQ_W-2:0], trial_ge};
      div_count <= div_count - DIV_CNT_W'(1);
    end
    if (cmd.load_out) begin
      period_ticks      <= period;
      frequency_q8      <= (den == '0) ? '0 : quo;
      zero_period_error <= (period == '0);
    end
  end

endmodule

@@ src/icfm_ctrl.sv @@
// ----------------------------------------------------------------------------
// icfm_ctrl
// Sequencer for the frequency meter: capture pairing, multiply and divide
// sequencing, and the output handshake.
// ----------------------------------------------------------------------------
module icfm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  icfm_pkg::dp_status_t status,
  output icfm_pkg::dp_cmd_t    cmd
);
  import icfm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   armed;
  logic   armed_next;
  logic   out_valid_next;
  logic   accept;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next     = state;
    armed_next     = armed;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (armed) begin
            cmd.store_period = 1'b1;
            armed_next       = 1'b0;
            state_next       = S_MUL;
          end else begin
            cmd.store_first = 1'b1;
            armed_next      = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd.load_div = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      armed     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      armed     <= armed_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ src/input_capture_frequency_meter.sv @@
// ----------------------------------------------------------------------------
// input_capture_frequency_meter
// Reciprocal frequency meter that pairs input capture timestamps and reports
// the period in ticks and the frequency in unsigned Q.8 hertz.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  input     in_valid / in_stall  capture_value
//  output    out_valid/ out_stall period_ticks, frequency_q8, zero_period_error
//  config    cfg_write            cfg_index, cfg_data
//
// A first capture is stored and produces no transaction.
// A second capture is accepted, then the denominator multiply runs, then the
// 36 steps of the one-bit restoring divider, then the load of the output
// register, which waits while the output holds a stalled result.
// A finished result waits in the output register while the next capture is
// accepted. Reset is synchronous and restores the default register values.
// ----------------------------------------------------------------------------
module input_capture_frequency_meter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [icfm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [icfm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [icfm_pkg::CAPTURE_W-1:0]   capture_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [icfm_pkg::CAPTURE_W-1:0]   period_ticks,
  output logic [icfm_pkg::FREQ_W-1:0]      frequency_q8,
  output logic                            zero_period_error
);
  import icfm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  icfm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  icfm_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .capture_value     (capture_value),
    .cmd               (cmd),
    .status            (status),
    .period_ticks      (period_ticks),
    .frequency_q8      (frequency_q8),
    .zero_period_error (zero_period_error)
  );

endmodule
